@@ rtl/dpa_pkg.sv @@
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared types and constants for the int8 dot product accelerator.
// ----------------------------------------------------------------------------
package dpa_pkg;

    localparam int LANES     = 8;
    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ACC_W     = 16 + $clog2(LANES);
    localparam int IDX_W     = 5;
    localparam int DATA_W    = 32;
    localparam int S_TDATA_W = 40;
    localparam int STEPS_W   = 5;

    localparam logic [IDX_W-1:0] IDX_CONTROL = 5'd0;
    localparam logic [IDX_W-1:0] IDX_STATUS  = 5'd1;
    localparam logic [IDX_W-1:0] IDX_RESULT  = 5'd2;
    localparam logic [IDX_W-1:0] IDX_STEPS   = 5'd3;
    localparam logic [IDX_W-1:0] IDX_A_BASE  = 5'd8;
    localparam logic [IDX_W-1:0] IDX_B_BASE  = 5'd16;
    localparam int               A_SPAN      = 8;
    localparam int               B_SPAN      = 16;
    localparam int               DONE_POS    = 1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic access;     // perform the accepted register access, load output
        logic mac_clear;  // clear the accumulator
        logic mac_step;   // one multiply-accumulate, rotate operands
        logic commit;     // store result and flags, load a zero output
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_start;   // incoming transaction is a start write
    } t_dp_status;

endpackage

@@ rtl/dpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpa_ctrl
// Controller: input/output handshake, MAC sequencing and lane counter.
// ----------------------------------------------------------------------------
module dpa_ctrl import dpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAC  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [LANE_W-1:0] r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;
    logic              w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_status.is_start) begin
                        o_cmd.mac_clear = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_MAC;
                    end else begin
                        o_cmd.access = 1'b1;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_LANE) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.access || o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // a pending output is never dropped while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("pending output lost under stall");

    // a start transaction enters the mac sequence
    a_start_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_status.is_start |=> r_state == S_MAC && r_cnt == '0)
        else $error("start did not enter mac sequence");

    // no new transaction accepted while busy
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_s_tready)
        else $error("input accepted during mac sequence");

    // finishing the sequence produces exactly one output
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && w_out_free |=> r_out_valid && r_state == S_IDLE)
        else $error("finish did not present output");

endmodule

@@ rtl/dpa_datapath.sv @@
// ----------------------------------------------------------------------------
// dpa_datapath
// Operand registers, multiply-accumulate unit, result registers and read mux.
// ----------------------------------------------------------------------------
module dpa_datapath import dpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [DATA_W-1:0]    o_m_tdata
);

    logic [7:0]               r_op_a [LANES];
    logic [7:0]               r_op_b [LANES];
    logic signed [ACC_W-1:0]  r_acc;
    logic [DATA_W-1:0]        r_dot_result;
    logic                     r_done;
    logic [STEPS_W-1:0]       r_steps;
    logic [DATA_W-1:0]        r_out_data;

    logic [IDX_W-1:0]         w_idx;
    logic [DATA_W-1:0]        w_wdata;
    logic                     w_write;
    logic [IDX_W-1:0]         w_a_off, w_b_off;
    logic                     w_a_hit, w_b_hit;
    logic [LANE_W-1:0]        w_a_sel, w_b_sel;
    logic [DATA_W-1:0]        w_rdata;
    logic signed [15:0]       w_prod;

    assign w_idx   = i_s_tdata[IDX_W-1:0];
    assign w_wdata = i_s_tdata[IDX_W +: DATA_W];
    assign w_write = (i_s_tuser == MODE_WRITE);

    assign w_a_off = w_idx - IDX_A_BASE;
    assign w_b_off = w_idx - IDX_B_BASE;
    assign w_a_hit = (w_idx >= IDX_A_BASE) && (w_a_off < IDX_W'(A_SPAN))
                     && (w_a_off < IDX_W'(LANES));
    assign w_b_hit = (w_idx >= IDX_B_BASE) && (w_b_off < IDX_W'(B_SPAN))
                     && (w_b_off < IDX_W'(LANES));
    assign w_a_sel = w_a_off[LANE_W-1:0];
    assign w_b_sel = w_b_off[LANE_W-1:0];

    assign o_status.is_start = w_write && (w_idx == IDX_CONTROL) && w_wdata[0];

    always_comb begin
        w_rdata = '0;
        priority if (w_idx == IDX_STATUS) begin
            w_rdata[DONE_POS] = r_done;
        end else if (w_idx == IDX_RESULT) begin
            w_rdata = r_dot_result;
        end else if (w_idx == IDX_STEPS) begin
            w_rdata = DATA_W'(r_steps);
        end else if (w_a_hit) begin
            w_rdata = {{(DATA_W-8){r_op_a[w_a_sel][7]}}, r_op_a[w_a_sel]};
        end else if (w_b_hit) begin
            w_rdata = {{(DATA_W-8){r_op_b[w_b_sel][7]}}, r_op_b[w_b_sel]};
        end else begin
            w_rdata = '0;
        end
    end

    // lane 0 always feeds the multiplier, the operands rotate each step
    assign w_prod = $signed(r_op_a[0]) * $signed(r_op_b[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_op_a[i] <= '0;
                r_op_b[i] <= '0;
            end
            r_dot_result <= '0;
            r_done       <= 1'b0;
            r_steps      <= '0;
        end else begin
            if (i_cmd.access && w_write && w_a_hit) begin
                r_op_a[w_a_sel] <= w_wdata[7:0];
            end
            if (i_cmd.access && w_write && w_b_hit) begin
                r_op_b[w_b_sel] <= w_wdata[7:0];
            end
            if (i_cmd.mac_step) begin
                for (int i = 0; i < LANES; i++) begin
                    r_op_a[i] <= r_op_a[(i + 1) % LANES];
                    r_op_b[i] <= r_op_b[(i + 1) % LANES];
                end
            end
            if (i_cmd.commit) begin
                r_dot_result <= DATA_W'(r_acc);
                r_done       <= 1'b1;
                r_steps      <= STEPS_W'(LANES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_clear) begin
            r_acc <= '0;
        end else if (i_cmd.mac_step) begin
            r_acc <= r_acc + ACC_W'(w_prod);
        end
        if (i_cmd.access) begin
            r_out_data <= w_write ? '0 : w_rdata;
        end else if (i_cmd.commit) begin
            r_out_data <= '0;
        end
    end

    assign o_m_tdata = r_out_data;

endmodule

@@ rtl/int8_dot_product_accelerator.sv @@
// ----------------------------------------------------------------------------
// int8_dot_product_accelerator
// Register-mapped signed int8 dot product unit, one register access per
// input transaction and one read value per output transaction.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: word_index, write_data
//                                                 tuser: mode
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: read_data
//
// A read or an ordinary write is performed on acceptance; its value sits in the
// output register the cycle after acceptance. A start write holds the input through
// the accepting cycle, LANES mac steps through the single multiply-accumulate unit
// and one commit; its zero value is loaded into the output register at the commit.
// Reset is synchronous, active low, and clears operands and result state. Input is
// accepted while the controller is idle and the output register is empty or being
// drained, so a read value held by a stalled output blocks new transactions and
// delays a pending commit until it is taken.
// ----------------------------------------------------------------------------
module int8_dot_product_accelerator import dpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [4:0] word_index, [36:5] write_data
    input  logic                 s_axis_tuser,   // [0] mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata    // [31:0] read_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dpa_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .i_s_tuser (s_axis_tuser),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_m_tdata (m_axis_tdata)
    );

endmodule

@@ tb/sv/int8_dot_product_accelerator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_dot_product_accelerator_checker
// Watches both stream channels of the dot product accelerator. Every accepted
// register access is run through a local copy of the operand, result and
// status registers to predict its read value. Every accepted output is
// compared against the oldest predicted value. Reports a running failure
// count and the number of read values still owed by the block.
// ----------------------------------------------------------------------------
module int8_dot_product_accelerator_checker import dpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,    // [4:0] word_index, [36:5] write_data
    input  logic                 i_s_tuser,    // [0] mode
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [DATA_W-1:0]    i_m_tdata,    // [31:0] read_data
    output int                   o_errors,
    output int                   o_outstanding
);

    logic signed [7:0]  model_a [LANES];
    logic signed [7:0]  model_b [LANES];
    logic [DATA_W-1:0]  model_dot;
    logic               model_done;
    logic [STEPS_W-1:0] model_steps;

    logic [DATA_W-1:0]  expected_read_data [$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    // applies one register access to the local register copy, returns the read value
    function automatic logic [DATA_W-1:0] apply_access(input logic mode,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] rd;
        logic signed [31:0] acc;
        int lane;
        rd = '0;
        if (mode == MODE_WRITE) begin
            if (idx == IDX_CONTROL) begin
                if (data[0]) begin
                    acc = 0;
                    for (int i = 0; i < LANES; i++) begin
                        acc = acc + model_a[i] * model_b[i];
                    end
                    model_dot   = acc;
                    model_steps = STEPS_W'(LANES);
                    model_done  = 1'b1;
                end
            end else if (idx >= IDX_A_BASE && idx < IDX_A_BASE + A_SPAN) begin
                lane = idx - IDX_A_BASE;
                if (lane < LANES) model_a[lane] = data[7:0];
            end else if (idx >= IDX_B_BASE && idx < IDX_B_BASE + B_SPAN) begin
                lane = idx - IDX_B_BASE;
                if (lane < LANES) model_b[lane] = data[7:0];
            end
        end else begin
            if (idx == IDX_STATUS) begin
                rd[DONE_POS] = model_done;
            end else if (idx == IDX_RESULT) begin
                rd = model_dot;
            end else if (idx == IDX_STEPS) begin
                rd = DATA_W'(model_steps);
            end else if (idx >= IDX_A_BASE && idx < IDX_A_BASE + A_SPAN) begin
                lane = idx - IDX_A_BASE;
                if (lane < LANES) rd = {{24{model_a[lane][7]}}, model_a[lane]};
            end else if (idx >= IDX_B_BASE && idx < IDX_B_BASE + B_SPAN) begin
                lane = idx - IDX_B_BASE;
                if (lane < LANES) rd = {{24{model_b[lane][7]}}, model_b[lane]};
            end
        end
        return rd;
    endfunction

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                model_a[i] = '0;
                model_b[i] = '0;
            end
            model_dot   = '0;
            model_done  = 1'b0;
            model_steps = '0;
            expected_read_data.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_read_data.size() == 0) begin
                    $display("%0t: unexpected read_data transaction, expected none, actual %08h",
                             $time, i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_read_data.pop_front();
                    if (i_m_tdata !== want) begin
                        $display("%0t: read_data mismatch, expected %08h, actual %08h",
                                 $time, want, i_m_tdata);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_read_data.push_back(apply_access(i_s_tuser, i_s_tdata[IDX_W-1:0],
                                                          i_s_tdata[IDX_W +: DATA_W]));
            end
        end
        o_outstanding <= expected_read_data.size();
    end

endmodule

@@ tb/sv/int8_dot_product_accelerator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_dot_product_accelerator_test
// Drives register accesses into the dot product accelerator: a directed pass
// over the register map and its corner cases, then random operand loads,
// start writes and readbacks mixed with random accesses, under random idle
// bursts on both channels. The checker beside the block predicts and
// compares; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module int8_dot_product_accelerator_test;
    import dpa_pkg::*;

    localparam int RANDOM_ITEMS = 1620;
    localparam int QUIET_FROM   = 1400;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata   = '0;   // [4:0] word_index, [36:5] write_data
    logic                 s_axis_tuser   = 1'b0; // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b1;
    logic [DATA_W-1:0]    m_axis_tdata;          // [31:0] read_data

    logic quiet_tail = 1'b0;
    int   sent_count = 0;
    int   error_count;
    int   outstanding;

    int8_dot_product_accelerator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    int8_dot_product_accelerator_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_errors      (error_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // read_data sink with random stall bursts
    initial begin
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!quiet_tail) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // one register access transaction, called just after a rising edge
    task automatic push_access(input logic mode, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] data);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_W'({$urandom(), $urandom()});
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({data, idx});
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        quiet_tail <= (sent_count >= QUIET_FROM);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // operand byte biased toward the signed extremes, zero, minus one and one, upper bits random
    function automatic logic [DATA_W-1:0] pick_operand(input int bias);
        logic [DATA_W-1:0] word;
        word = $urandom();
        case (bias)
            0: word[7:0] = 8'h80;
            1: word[7:0] = 8'h7F;
            2: word[7:0] = 8'h00;
            3: word[7:0] = 8'hFF;
            4: word[7:0] = 8'h01;
            default: ;
        endcase
        return word;
    endfunction

    // load some or all lanes, start, then read back status, result and sometimes steps
    task automatic run_dot_sequence();
        int kind;
        int a_bias;
        int b_bias;
        bit full;
        kind = $urandom_range(0, 9);
        full = (kind < 5) || $urandom_range(0, 1);
        case (kind)
            0: begin a_bias = 0; b_bias = 0; end
            1: begin a_bias = 0; b_bias = 1; end
            2: begin a_bias = 1; b_bias = 1; end
            3: begin a_bias = 1; b_bias = 0; end
            default: begin a_bias = -1; b_bias = -1; end
        endcase
        if ($urandom_range(0, 3) == 0) push_access(MODE_READ, IDX_STATUS, $urandom());
        for (int i = 0; i < LANES; i++) begin
            if (full || $urandom_range(0, 1))
                push_access(MODE_WRITE, IDX_W'(IDX_A_BASE + i),
                            pick_operand(a_bias < 0 ? $urandom_range(0, 8) : a_bias));
            if (full || $urandom_range(0, 1))
                push_access(MODE_WRITE, IDX_W'(IDX_B_BASE + i),
                            pick_operand(b_bias < 0 ? $urandom_range(0, 8) : b_bias));
            if ($urandom_range(0, 7) == 0)
                push_access(MODE_READ, IDX_W'(IDX_A_BASE + $urandom_range(0, LANES - 1)),
                            $urandom());
        end
        push_access(MODE_WRITE, IDX_CONTROL, $urandom() | 32'h1);
        push_access(MODE_READ, IDX_STATUS, $urandom());
        push_access(MODE_READ, IDX_RESULT, $urandom());
        if ($urandom_range(0, 1)) push_access(MODE_READ, IDX_STEPS, $urandom());
        if ($urandom_range(0, 2) == 0)
            push_access(MODE_READ, IDX_W'(IDX_B_BASE + $urandom_range(0, LANES - 1)),
                        $urandom());
    endtask

    initial begin
        logic [DATA_W-1:0] noise;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values
        push_access(MODE_READ,  IDX_STATUS,  32'hFFFF_FFFF);
        push_access(MODE_READ,  IDX_RESULT,  32'h0);
        push_access(MODE_READ,  IDX_STEPS,   32'h0);
        push_access(MODE_READ,  IDX_CONTROL, 32'h0);
        push_access(MODE_READ,  IDX_A_BASE,  32'h0);
        // operand extremes with junk in the upper bits
        push_access(MODE_WRITE, IDX_A_BASE,               32'hFFFF_FF7F);
        push_access(MODE_WRITE, IDX_W'(IDX_A_BASE + 1),   32'h0000_0080);
        push_access(MODE_WRITE, IDX_B_BASE,               32'h5555_5580);
        push_access(MODE_WRITE, IDX_W'(IDX_B_BASE + 1),   32'hAAAA_AA80);
        push_access(MODE_WRITE, IDX_W'(IDX_A_BASE + 7),   32'h1234_56FF);
        push_access(MODE_WRITE, IDX_W'(IDX_B_BASE + 7),   32'hAAAA_AA01);
        // control write without start bit leaves done clear, then a start write sets it
        push_access(MODE_WRITE, IDX_CONTROL, 32'hFFFF_FFFE);
        push_access(MODE_READ,  IDX_STATUS,  32'h0);
        push_access(MODE_WRITE, IDX_CONTROL, 32'h0000_0001);
        push_access(MODE_READ,  IDX_STATUS,  32'h0);
        push_access(MODE_READ,  IDX_RESULT,  32'h0);
        push_access(MODE_READ,  IDX_STEPS,   32'h0);
        // writes to read-only and unmapped words are dropped
        push_access(MODE_WRITE, IDX_STATUS,  32'hFFFF_FFFF);
        push_access(MODE_WRITE, IDX_RESULT,  32'hFFFF_FFFF);
        push_access(MODE_WRITE, 5'd31,       32'hFFFF_FFFF);
        // B lane beyond the lane count and unmapped reads return zero, then an A lane is read back
        push_access(MODE_READ,  IDX_W'(IDX_B_BASE + LANES), 32'h0);
        push_access(MODE_READ,  5'd4,        32'h0);
        push_access(MODE_READ,  IDX_W'(IDX_A_BASE + 1), 32'h0);
        // start again while done
        push_access(MODE_WRITE, IDX_CONTROL, 32'hFFFF_FFFF);
        push_access(MODE_READ,  IDX_RESULT,  32'h0);
        wait_drained();
        @(posedge i_clk);

        while (sent_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                run_dot_sequence();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    noise = $urandom();
                    if ($urandom_range(0, 5) == 0) noise[0] = 1'b0;
                    push_access(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 31)),
                                noise);
                end
            end
        end

        wait_drained();
        repeat (LANES + 8) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
